FILE: sv/chash_pkg.sv
// Shared types, codes and constants for the chained hash accumulator.
package chash_pkg;

   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int FIELD_W    = 32;
   localparam int COUNT_W    = 10;
   localparam int HASH_BITS  = 32;
   localparam int MOD_DIGIT  = 4;
   localparam int MOD_STEPS  = HASH_BITS / MOD_DIGIT;

   localparam int DEF_NUM_BUCKETS = 1024;
   localparam int DEF_NUM_ENTRIES = 1024;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_VALUE_BITS  = 32;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_MOD,
      S_HREAD,
      S_HWAIT,
      S_EREAD,
      S_ECMP,
      S_UNLINK1,
      S_UNLINK2,
      S_ALLOC,
      S_AWAIT,
      S_AWRITE,
      S_RESP
   } state_type;

endpackage

FILE: sv/chash_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chash_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/chash_mod.sv
// Hash-to-bucket remainder unit, four hash bits per cycle.
module chash_mod #(
   parameter int NUM_BUCKETS = chash_pkg::DEF_NUM_BUCKETS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [chash_pkg::HASH_BITS-1:0] hash,
   output logic                           done,
   output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);
   import chash_pkg::*;

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int SW = $clog2(MOD_STEPS);
   localparam logic [BW:0] NB = (BW+1)'(NUM_BUCKETS);

   logic [BW:0]          rem_ff, rem_in;
   logic [HASH_BITS-1:0] sh_ff, sh_in;
   logic [SW-1:0]        step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [BW:0] r;
      r       = rem_ff;
      sh_in   = sh_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r       = '0;
         sh_in   = hash;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int j = 0; j < MOD_DIGIT; j++) begin
            r = {r[BW-1:0], sh_ff[HASH_BITS-1-j]};
            if (r >= NB) begin
               r = r - NB;
            end
         end
         sh_in   = sh_ff << MOD_DIGIT;
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(MOD_STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff[BW-1:0];

endmodule

FILE: sv/chained_hash_accumulator.sv
// Chained hash accumulator top level: control sequencer, bucket and entry memories.
//
// Requests arrive on req_* (valid/ready) with mode, key, hash and amount; one
// response per request leaves on rsp_* (valid/ready) with status, value and
// the live entry count. csr_* writes the drop-zero-sums bit; it is always ready
// and should be written while the block is idle.
// One request is worked at a time. The hash remainder unit runs first; then
// the bucket head is read, each chain entry visited is read and compared
// through the entry memory, removal frees the entry and relinks the chain,
// allocation takes a free-list or unused slot, and the response register is loaded.
// Unused modes, zero adds and full inserts go straight to the response.
// A clear request sweeps all bucket heads, one per cycle.
// After reset the same sweep runs over all bucket heads before req_ready rises.
// A finished response waits in the output register while rsp_ready is low; a
// new request is taken meanwhile, and the block holds its next response
// until the register frees.
module chained_hash_accumulator #(
   parameter int NUM_BUCKETS = chash_pkg::DEF_NUM_BUCKETS,
   parameter int NUM_ENTRIES = chash_pkg::DEF_NUM_ENTRIES,
   parameter int KEY_BITS    = chash_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS  = chash_pkg::DEF_VALUE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [chash_pkg::MODE_W-1:0]          req_mode,
   input  logic [chash_pkg::FIELD_W-1:0]         req_key,
   input  logic [chash_pkg::FIELD_W-1:0]         req_hash,
   input  logic signed [chash_pkg::FIELD_W-1:0]  req_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [chash_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [chash_pkg::FIELD_W-1:0]  rsp_result_value,
   output logic [chash_pkg::COUNT_W-1:0]         rsp_entry_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_drop_zero_sums
);
   import chash_pkg::*;

   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int EW    = $clog2(NUM_ENTRIES);
   localparam int EWORD = KEY_BITS + VALUE_BITS + EW;

   state_type state_ff, state_in;

   logic [MODE_W-1:0]            mode_ff, mode_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic signed [VALUE_BITS-1:0] amt_ff, amt_in;
   logic [EW-1:0]                head_ff, head_in;
   logic [EW-1:0]                cur_ff, cur_in;
   logic [EW-1:0]                prev_ff, prev_in;
   logic [EW-1:0]                slot_ff, slot_in;
   logic [EWORD-1:0]             cword_ff, cword_in;
   logic [EWORD-1:0]             pword_ff, pword_in;
   logic [STATUS_W-1:0]          st_ff, st_in;
   logic signed [VALUE_BITS-1:0] res_ff, res_in;
   logic [EW-1:0]                cnt_ff, cnt_in;
   logic [EW-1:0]                free_ff, free_in;
   logic [EW-1:0]                next_ff, next_in;
   logic [BW-1:0]                sweep_ff, sweep_in;
   logic                         clr_item_ff, clr_item_in;
   logic                         drop_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]          rsp_status_ff, rsp_status_in;
   logic signed [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [EW-1:0]                rsp_count_ff, rsp_count_in;

   logic                 accept, full, rsp_free, sweep_last, mod_start, mod_done;
   logic [BW-1:0]        bkt;
   logic signed [VALUE_BITS-1:0] req_amt;

   logic                 b_wr_en, b_rd_en;
   logic [BW-1:0]        b_wr_addr;
   logic [EW-1:0]        b_wr_data, b_rd_data;
   logic                 e_wr_en, e_rd_en;
   logic [EW-1:0]        e_wr_addr, e_rd_addr;
   logic [EWORD-1:0]     e_wr_data, e_rd_data;

   logic [KEY_BITS-1:0]          r_key;
   logic signed [VALUE_BITS-1:0] r_val, sum;
   logic [EW-1:0]                r_link, c_link;
   logic                         match, drop_now;

   chash_mod #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .hash   (req_hash),
      .done   (mod_done),
      .bucket (bkt)
   );

   chash_ram #(.WIDTH(EW), .DEPTH(NUM_BUCKETS)) u_heads (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_en   (b_rd_en),
      .rd_addr (bkt),
      .rd_data (b_rd_data)
   );

   chash_ram #(.WIDTH(EWORD), .DEPTH(NUM_ENTRIES)) u_entries (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_en   (e_rd_en),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign req_amt    = VALUE_BITS'(req_amount);
   assign full       = (cnt_ff >= EW'(NUM_ENTRIES - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign sweep_last = (sweep_ff == BW'(NUM_BUCKETS - 1));

   assign r_key    = e_rd_data[EWORD-1 -: KEY_BITS];
   assign r_val    = e_rd_data[VALUE_BITS+EW-1 -: VALUE_BITS];
   assign r_link   = e_rd_data[EW-1:0];
   assign c_link   = cword_ff[EW-1:0];
   assign match    = (r_key == key_ff);
   assign sum      = r_val + amt_ff;
   assign drop_now = drop_ff && (sum == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_SWEEP: begin
            if (sweep_last) begin
               state_in = clr_item_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_CLEAR:               state_in = S_SWEEP;
                  MODE_LOOKUP, MODE_REMOVE: state_in = S_MOD;
                  MODE_INSERT:              state_in = full ? S_RESP : S_MOD;
                  MODE_ADD:                 state_in = (req_amt == '0) ? S_RESP : S_MOD;
                  default:                  state_in = S_RESP;
               endcase
            end
         end
         S_MOD:   if (mod_done) state_in = S_HREAD;
         S_HREAD: state_in = S_HWAIT;
         S_HWAIT: state_in = (mode_ff == MODE_INSERT) ? S_ALLOC : S_EREAD;
         S_EREAD: begin
            if (cur_ff != '0) begin
               state_in = S_ECMP;
            end else if (mode_ff == MODE_ADD && !full) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ECMP: begin
            if (!match) begin
               state_in = S_EREAD;
            end else if (mode_ff == MODE_REMOVE || (mode_ff == MODE_ADD && drop_now)) begin
               state_in = S_UNLINK1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_UNLINK1: state_in = (prev_ff == '0) ? S_RESP : S_UNLINK2;
         S_UNLINK2: state_in = S_RESP;
         S_ALLOC:   state_in = (free_ff != '0) ? S_AWAIT : S_AWRITE;
         S_AWAIT:   state_in = S_AWRITE;
         S_AWRITE:  state_in = S_RESP;
         S_RESP:    if (rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      slot_in       = slot_ff;
      cword_in      = cword_ff;
      pword_in      = pword_ff;
      st_in         = st_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      next_in       = next_ff;
      sweep_in      = sweep_ff;
      clr_item_in   = clr_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mod_start     = 1'b0;
      b_wr_en       = 1'b0;
      b_wr_addr     = bkt;
      b_wr_data     = '0;
      b_rd_en       = 1'b0;
      e_wr_en       = 1'b0;
      e_wr_addr     = cur_ff;
      e_wr_data     = cword_ff;
      e_rd_en       = 1'b0;
      e_rd_addr     = cur_ff;
      case (state_ff)
         S_SWEEP: begin
            b_wr_en   = 1'b1;
            b_wr_addr = sweep_ff;
            sweep_in  = sweep_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               mode_in     = req_mode;
               key_in      = KEY_BITS'(req_key);
               amt_in      = req_amt;
               st_in       = ST_OK;
               res_in      = '0;
               clr_item_in = 1'b0;
               case (req_mode)
                  MODE_CLEAR: begin
                     clr_item_in = 1'b1;
                     sweep_in    = '0;
                     cnt_in      = '0;
                     free_in     = '0;
                     next_in     = EW'(1);
                  end
                  MODE_LOOKUP, MODE_REMOVE: mod_start = 1'b1;
                  MODE_INSERT: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else begin
                        mod_start = 1'b1;
                     end
                  end
                  MODE_ADD: mod_start = (req_amt != '0);
                  default: ;
               endcase
            end
         end
         S_MOD: ;
         S_HREAD: b_rd_en = 1'b1;
         S_HWAIT: begin
            head_in = b_rd_data;
            cur_in  = b_rd_data;
            prev_in = '0;
         end
         S_EREAD: begin
            if (cur_ff != '0) begin
               e_rd_en = 1'b1;
            end else if (mode_ff == MODE_ADD) begin
               st_in = full ? ST_FULL : ST_OK;
            end else begin
               st_in = ST_ABSENT;
            end
         end
         S_ECMP: begin
            if (!match) begin
               prev_in  = cur_ff;
               pword_in = e_rd_data;
               cur_in   = r_link;
            end else begin
               cword_in = e_rd_data;
               case (mode_ff)
                  MODE_ADD: begin
                     cword_in = {r_key, sum, r_link};
                     if (drop_now) begin
                        st_in = ST_DROPPED;
                     end else begin
                        res_in    = sum;
                        e_wr_en   = 1'b1;
                        e_wr_data = {r_key, sum, r_link};
                     end
                  end
                  default: res_in = r_val;
               endcase
            end
         end
         S_UNLINK1: begin
            e_wr_en   = 1'b1;
            e_wr_addr = cur_ff;
            e_wr_data = {cword_ff[EWORD-1:EW], free_ff};
            free_in   = cur_ff;
            cnt_in    = cnt_ff - 1'b1;
            if (prev_ff == '0) begin
               b_wr_en   = 1'b1;
               b_wr_data = c_link;
            end
         end
         S_UNLINK2: begin
            e_wr_en   = 1'b1;
            e_wr_addr = prev_ff;
            e_wr_data = {pword_ff[EWORD-1:EW], c_link};
         end
         S_ALLOC: begin
            if (free_ff != '0) begin
               e_rd_en   = 1'b1;
               e_rd_addr = free_ff;
               slot_in   = free_ff;
            end else begin
               slot_in = next_ff;
               next_in = next_ff + 1'b1;
            end
         end
         S_AWAIT: free_in = r_link;
         S_AWRITE: begin
            e_wr_en   = 1'b1;
            e_wr_addr = slot_ff;
            e_wr_data = {key_ff, amt_ff, head_ff};
            b_wr_en   = 1'b1;
            b_wr_data = slot_ff;
            cnt_in    = cnt_ff + 1'b1;
            st_in     = ST_OK;
            res_in    = amt_ff;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_value_in  = res_ff;
               rsp_count_in  = cnt_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         clr_item_ff  <= 1'b0;
         cnt_ff       <= '0;
         free_ff      <= '0;
         next_ff      <= EW'(1);
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_item_ff  <= clr_item_in;
         cnt_ff       <= cnt_in;
         free_ff      <= free_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            drop_ff <= csr_drop_zero_sums;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      slot_ff       <= slot_in;
      cword_ff      <= cword_in;
      pword_ff      <= pword_in;
      st_ff         <= st_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = FIELD_W'(rsp_value_ff);
   assign rsp_entry_count  = COUNT_W'(rsp_count_ff);

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= EW'(NUM_ENTRIES - 1))
      else $error("live count beyond store capacity");

   a_unused_slots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && free_ff == '0) |-> (next_ff == cnt_ff + 1'b1))
      else $error("unused slot pointer out of step with live count");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");
`endif

endmodule

FILE: bench/chained_hash_accumulator_tb.sv
// Self-checking testbench for the chained hash accumulator: table model, scoreboard and drivers.
`timescale 1ns / 100ps

module chained_hash_accumulator_tb;
   import chash_pkg::*;

   localparam int BUCKETS       = DEF_NUM_BUCKETS;
   localparam int ENTRIES       = DEF_NUM_ENTRIES;
   localparam int WATCHDOG_MAX  = 60000;
   localparam int PHASE_ITEMS   = 170;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  value;
      logic [COUNT_W-1:0]  count;
   } outcome_t;

   class hash_table_scoreboard;
      bit [COUNT_W-1:0] bucket_first[BUCKETS];
      bit [FIELD_W-1:0] slot_key[ENTRIES];
      bit [FIELD_W-1:0] slot_sum[ENTRIES];
      bit [COUNT_W-1:0] slot_next[ENTRIES];
      int unsigned      live;
      int unsigned      free_top;
      int unsigned      fresh_slot;
      bit               drop_zero;
      outcome_t         pending[$];
      int               mismatches;

      function void wipe();
         foreach (bucket_first[b]) bucket_first[b] = '0;
         live = 0;
         free_top = 0;
         fresh_slot = 1;
      endfunction

      function int find_slot(int b, bit [FIELD_W-1:0] k, output int prev);
         int i;
         i = bucket_first[b];
         prev = 0;
         while (i != 0 && slot_key[i] != k) begin
            prev = i;
            i = slot_next[i];
         end
         return i;
      endfunction

      function void unlink(int b, int i, int prev);
         if (prev == 0) bucket_first[b] = slot_next[i];
         else slot_next[prev] = slot_next[i];
         slot_next[i] = free_top;
         free_top = i;
         live--;
      endfunction

      function void link_new(int b, bit [FIELD_W-1:0] k, bit [FIELD_W-1:0] v);
         int i;
         if (free_top != 0) begin
            i = free_top;
            free_top = slot_next[i];
         end else begin
            i = fresh_slot;
            fresh_slot++;
         end
         slot_key[i] = k;
         slot_sum[i] = v;
         slot_next[i] = bucket_first[b];
         bucket_first[b] = i;
         live++;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] key,
                                 logic [FIELD_W-1:0] hash, logic [FIELD_W-1:0] amount);
         outcome_t o;
         int b, i, prev;
         bit [FIELD_W-1:0] s;
         b = hash % BUCKETS;
         o = '0;
         o.status = ST_OK;
         case (mode)
            MODE_LOOKUP: begin
               i = find_slot(b, key, prev);
               if (i == 0) o.status = ST_ABSENT;
               else o.value = slot_sum[i];
            end
            MODE_INSERT: begin
               if (live + 1 > ENTRIES - 1) o.status = ST_FULL;
               else begin
                  link_new(b, key, amount);
                  o.value = amount;
               end
            end
            MODE_REMOVE: begin
               i = find_slot(b, key, prev);
               if (i == 0) o.status = ST_ABSENT;
               else begin
                  o.value = slot_sum[i];
                  unlink(b, i, prev);
               end
            end
            MODE_ADD: begin
               if (amount != 0) begin
                  i = find_slot(b, key, prev);
                  if (i != 0) begin
                     s = slot_sum[i] + amount;
                     slot_sum[i] = s;
                     if (s == 0 && drop_zero) begin
                        unlink(b, i, prev);
                        o.status = ST_DROPPED;
                     end else o.value = s;
                  end else if (live + 1 > ENTRIES - 1) o.status = ST_FULL;
                  else begin
                     link_new(b, key, amount);
                     o.value = amount;
                  end
               end
            end
            MODE_CLEAR: wipe();
            default: ;
         endcase
         o.count = live[COUNT_W-1:0];
         pending.push_back(o);
      endfunction

      function bit check_response(outcome_t got);
         outcome_t want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response status=%0d value=%0d count=%0d",
                        got.status, $signed(got.value), got.count);
            return 0;
         end
         want = pending.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected status=%0d value=%0d count=%0d, got %0d %0d %0d",
                        want.status, $signed(want.value), want.count,
                        got.status, $signed(got.value), got.count);
            return 0;
         end
         return 1;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [MODE_W-1:0] req_mode = '0;
   logic [FIELD_W-1:0] req_key = '0;
   logic [FIELD_W-1:0] req_hash = '0;
   logic signed [FIELD_W-1:0] req_amount = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [FIELD_W-1:0] rsp_result_value;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_drop_zero_sums = 0;

   hash_table_scoreboard table_model = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   bit [FIELD_W-1:0] key_pool[12] = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h80000000,
      32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h12, 32'h13, 32'h14, 32'h400, 32'h15};
   bit [FIELD_W-1:0] hash_pool[6] = '{32'h0, 32'h400, 32'hFFFFFFFF, 32'h5,
      32'h405, 32'h3FF};
   bit [FIELD_W-1:0] amount_pool[6] = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
      32'h1, 32'h80000001, 32'h0};

   chained_hash_accumulator dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else begin
         if (rsp_valid && rsp_ready)
            void'(table_model.check_response({rsp_status, rsp_result_value,
                                              rsp_entry_count}));
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_request(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] key,
                               logic [FIELD_W-1:0] hash, logic [FIELD_W-1:0] amount);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_key <= key;
      req_hash <= hash;
      req_amount <= amount;
      do @(posedge clock); while (!req_ready);
      table_model.note_request(mode, key, hash, amount);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_drop(bit value);
      csr_valid <= 1;
      csr_drop_zero_sums <= value;
      do @(posedge clock); while (!csr_ready);
      table_model.drop_zero = value;
      csr_valid <= 0;
   endtask

   function automatic bit [FIELD_W-1:0] pick_key();
      return ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 11)] : $urandom;
   endfunction

   function automatic bit [FIELD_W-1:0] pick_hash();
      return ($urandom_range(0, 9) < 7) ? hash_pool[$urandom_range(0, 5)] : $urandom;
   endfunction

   function automatic bit [FIELD_W-1:0] pick_amount();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 6) - 3;
      if (r < 7) return amount_pool[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return MODE_LOOKUP;
      if (r < 40) return MODE_INSERT;
      if (r < 55) return MODE_REMOVE;
      if (r < 94) return MODE_ADD;
      if (r < 96) return MODE_CLEAR;
      return 3'($urandom_range(5, 7));
   endfunction

   initial begin
      table_model.wipe();
      repeat (10) @(posedge clock);
      reset <= 0;
      write_drop(0);

      send_request(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(MODE_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
      send_request(MODE_INSERT, 32'h0, 32'h0, 32'h7FFFFFFF);
      send_request(MODE_INSERT, 32'hFFFFFFFF, 32'h400, 32'h80000000);
      send_request(MODE_INSERT, 32'h0, 32'h400, 32'h5);
      send_request(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(MODE_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0);
      send_request(MODE_ADD, 32'h0, 32'h0, 32'h1);
      send_request(MODE_ADD, 32'h0, 32'h0, 32'h0);
      send_request(MODE_ADD, 32'h0, 32'h0, 32'hFFFFFFFB);
      send_request(MODE_ADD, 32'h7, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_request(MODE_REMOVE, 32'h0, 32'h0, 32'h0);
      send_request(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);
      send_request(3'd5, 32'h1, 32'h1, 32'h1);
      send_request(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_request(MODE_REMOVE, 32'hFFFFFFFF, 32'h400, 32'h0);
      send_request(MODE_INSERT, 32'h9, 32'h400, 32'h3);
      drain();
      write_drop(1);
      send_request(MODE_ADD, 32'h9, 32'h400, 32'hFFFFFFFD);
      send_request(MODE_LOOKUP, 32'h9, 32'h400, 32'h0);
      send_request(MODE_CLEAR, 32'h0, 32'h0, 32'h0);
      send_request(MODE_LOOKUP, 32'h7, 32'hFFFFFFFF, 32'h0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 56; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 56; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         write_drop(phase[0]);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(pick_mode(), pick_key(), pick_hash(), pick_amount());
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 8;
      write_drop(1);
      send_request(MODE_CLEAR, 32'h0, 32'h0, 32'h0);
      for (int n = 0; n < ENTRIES + 4; n++)
         send_request(MODE_INSERT, $urandom, $urandom, $urandom);
      send_request(MODE_ADD, 32'h12345678, 32'h5, 32'h1);
      send_request(MODE_REMOVE, table_model.slot_key[1], 32'h0, 32'h0);
      for (int n = 0; n < 30; n++)
         send_request(pick_mode(), pick_key(), pick_hash(), pick_amount());
      drain();

      if (table_model.mismatches == 0 && table_model.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: files.f
sv/chash_pkg.sv
sv/chash_ram.sv
sv/chash_mod.sv
sv/chained_hash_accumulator.sv
bench/chained_hash_accumulator_tb.sv
